// ----- rtl/core/gppc_pkg.sv -----
`default_nettype none
package gppc_pkg;

	localparam int MAX_BATCH_ITEMS = 4096;
	// holds the saturated count MAX_BATCH_ITEMS + 1
	localparam int ITEMS_W = $clog2(MAX_BATCH_ITEMS + 2);
	localparam int COUNT_W = 13;
	localparam int GIDX_W = 12;
	localparam int ROUND_MASK = 3;

	localparam int CFG_INDEX_W = 4;
	localparam logic [CFG_INDEX_W-1:0] CFG_METADATA_SIZE = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OBJECT_SIZE = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_GROUP_BYTES = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_GROUP_OBJECTS = 4'd3;

	localparam logic [63:0] RST_METADATA_SIZE = 64'd0;
	localparam logic [63:0] RST_MAX_OBJECT_SIZE = '1;
	localparam logic [63:0] RST_MAX_GROUP_BYTES = 64'd1048576;
	localparam logic [COUNT_W-1:0] RST_MAX_GROUP_OBJECTS = 13'd64;

	localparam logic [1:0] TR_FIRST = 2'd1;
	localparam logic [1:0] TR_SECOND = 2'd2;

	localparam int S_TDATA_W = 408;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 96;

	typedef struct packed {
		logic [63:0] metadata_size;
		logic [63:0] max_object_size;
		logic [63:0] max_group_bytes;
		logic [COUNT_W-1:0] max_group_objects;
	} cfg_t;

	typedef struct packed {
		logic batch_last;
		logic gather_allowed;
		logic [63:0] header_metadata_size;
		logic [63:0] payload_size;
		logic [1:0] transport;
		logic [63:0] target_address;
		logic [63:0] region_key;
		logic [31:0] host_tag;
		logic [15:0] port_number;
		logic [63:0] peer_tag;
		logic chip_present;
		logic [31:0] chip_number;
	} item_t;

	typedef struct packed {
		logic batch_last;
		logic static_bad;
		logic [63:0] aligned;
		logic [1:0] transport;
		logic [63:0] target_address;
		logic addr_below_meta;
		logic [63:0] region_key;
		logic [31:0] host_tag;
		logic [15:0] port_number;
		logic [63:0] peer_tag;
		logic [32:0] chip;
	} prep_t;

	typedef struct packed {
		logic starts_group;
		logic [GIDX_W-1:0] group_index;
		logic [63:0] aligned_size;
		logic batch_done;
		logic plan_ok;
		logic [COUNT_W-1:0] group_total;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/core/gather_plan_partition_check_unit.sv -----
`default_nettype none
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    s_tdata, s_tuser, s_tlast (batch_last)
// m_*       out  m_tvalid / m_tready    m_tdata, m_tlast (batch_done)
// cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat per cycle sustained while m_tready accepts results; each beat passes the stages below in order.
// Stages: input register, size/rounding register, plan-state update into the result register.
// A stalled result holds in the result register; ready propagates back stage by stage.
// arst_n clears the pipeline, the batch state and loads the register defaults.
// cfg_ready is always high.
module gather_plan_partition_check_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output      logic                                s_tready,
	// gather_allowed, header_metadata_size, payload_size, target_address, region_key,
	// host_tag, port_number, peer_tag, chip_number, zero pad
	input  wire logic [gppc_pkg::S_TDATA_W-1:0]      s_tdata,
	// transport, chip_present
	input  wire logic [gppc_pkg::S_TUSER_W-1:0]      s_tuser,
	input  wire logic                                s_tlast,
	output      logic                                m_tvalid,
	input  wire logic                                m_tready,
	// starts_group, group_index, aligned_size, plan_ok, group_total, zero pad
	output      logic [gppc_pkg::M_TDATA_W-1:0]      m_tdata,
	output      logic                                m_tlast,
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [gppc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [63:0]                         cfg_data
);

	gppc_pkg::cfg_t    cfg;
	gppc_pkg::item_t   item_in;
	gppc_pkg::item_t   item_s1;
	gppc_pkg::prep_t   prep_comb;
	gppc_pkg::prep_t   prep_s2;
	gppc_pkg::result_t res_comb;
	gppc_pkg::result_t res_q;
	logic              valid_s1;
	logic              valid_s2;
	logic              out_valid_q;
	logic              out_free;
	logic              s2_free;
	logic              s1_free;
	logic              step;

	gppc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_comb begin
		item_in.batch_last = s_tlast;
		item_in.gather_allowed = s_tdata[0];
		item_in.header_metadata_size = s_tdata[64:1];
		item_in.payload_size = s_tdata[128:65];
		item_in.transport = s_tuser[1:0];
		item_in.target_address = s_tdata[192:129];
		item_in.region_key = s_tdata[256:193];
		item_in.host_tag = s_tdata[288:257];
		item_in.port_number = s_tdata[304:289];
		item_in.peer_tag = s_tdata[368:305];
		item_in.chip_present = s_tuser[2];
		item_in.chip_number = s_tdata[400:369];
	end

	assign out_free = !out_valid_q || m_tready;
	assign s2_free = !valid_s2 || out_free;
	assign s1_free = !valid_s1 || s2_free;
	assign s_tready = s1_free;
	assign step = valid_s2 && out_free;

	gppc_size_stage u_size (
		.item (item_s1),
		.cfg  (cfg),
		.prep (prep_comb)
	);

	gppc_plan_state u_plan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.prep   (prep_s2),
		.cfg    (cfg),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) valid_s1 <= s_tvalid;
			if (s2_free) valid_s2 <= valid_s1;
			if (out_free) out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s1_free) item_s1 <= item_in;
		if (valid_s1 && s2_free) prep_s2 <= prep_comb;
		if (step) res_q <= res_comb;
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast = res_q.batch_done;
	assign m_tdata = {5'd0, res_q.group_total, res_q.plan_ok, res_q.aligned_size,
		res_q.group_index, res_q.starts_group};

endmodule
`default_nettype wire

// ----- rtl/core/gppc_cfg_regs.sv -----
`default_nettype none
module gppc_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [gppc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [63:0]                         cfg_data,
	output      gppc_pkg::cfg_t                      cfg
);

	gppc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.metadata_size <= gppc_pkg::RST_METADATA_SIZE;
			cfg_q.max_object_size <= gppc_pkg::RST_MAX_OBJECT_SIZE;
			cfg_q.max_group_bytes <= gppc_pkg::RST_MAX_GROUP_BYTES;
			cfg_q.max_group_objects <= gppc_pkg::RST_MAX_GROUP_OBJECTS;
		end else if (cfg_valid) begin
			case (cfg_index)
				gppc_pkg::CFG_METADATA_SIZE: cfg_q.metadata_size <= cfg_data;
				gppc_pkg::CFG_MAX_OBJECT_SIZE: cfg_q.max_object_size <= cfg_data;
				gppc_pkg::CFG_MAX_GROUP_BYTES: cfg_q.max_group_bytes <= cfg_data;
				gppc_pkg::CFG_MAX_GROUP_OBJECTS: begin
					cfg_q.max_group_objects <= cfg_data[gppc_pkg::COUNT_W-1:0];
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/gppc_size_stage.sv -----
`default_nettype none
module gppc_size_stage (
	input  wire gppc_pkg::item_t item,
	input  wire gppc_pkg::cfg_t  cfg,
	output      gppc_pkg::prep_t prep
);

	logic [65:0] sum;
	logic        sum_ok;

	// data + metadata + 3 in one add; no carry out means neither step overflows
	assign sum = {2'b00, item.payload_size} + {2'b00, cfg.metadata_size}
		+ 66'(gppc_pkg::ROUND_MASK);
	assign sum_ok = (sum[65:64] == 2'b00);

	always_comb begin
		prep.batch_last = item.batch_last;
		prep.aligned = sum_ok ? {sum[63:2], 2'b00} : 64'd0;
		prep.static_bad = !item.gather_allowed
			|| (item.header_metadata_size != cfg.metadata_size)
			|| (cfg.max_group_bytes == 64'd0)
			|| (cfg.max_group_objects == '0)
			|| (item.payload_size > cfg.max_object_size)
			|| !sum_ok;
		prep.transport = item.transport;
		prep.target_address = item.target_address;
		prep.addr_below_meta = item.target_address < cfg.metadata_size;
		prep.region_key = item.region_key;
		prep.host_tag = item.host_tag;
		prep.port_number = item.port_number;
		prep.peer_tag = item.peer_tag;
		prep.chip = item.chip_present ? {1'b1, item.chip_number} : 33'd0;
	end

endmodule
`default_nettype wire

// ----- rtl/core/gppc_plan_state.sv -----
`default_nettype none
module gppc_plan_state (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire gppc_pkg::prep_t prep,
	input  wire gppc_pkg::cfg_t  cfg,
	output      gppc_pkg::result_t res
);

	localparam int CW = gppc_pkg::COUNT_W;
	localparam int IW = gppc_pkg::ITEMS_W;

	logic          plan_failed_q;
	logic [CW-1:0] items_in_group_q;
	logic [63:0]   group_bytes_q;
	logic [CW-1:0] groups_closed_q;
	logic [IW-1:0] items_seen_q;
	logic [63:0]   expected_address_q;
	logic [1:0]    group_transport_q;
	logic [63:0]   group_region_q;
	logic [31:0]   group_host_q;
	logic [15:0]   group_port_q;
	logic [63:0]   group_peer_q;
	logic [32:0]   group_chip_q;

	logic          item_bad;
	logic          active;
	logic          open_grp;
	logic          close_grp;
	logic          same_dest;
	logic          new_fail;
	logic [63:0]   room;
	logic [63:0]   base;
	logic [64:0]   next_addr;
	logic          plan_failed_d;
	logic [CW-1:0] items_in_group_d;
	logic [63:0]   group_bytes_d;
	logic [CW-1:0] groups_closed_d;
	logic [IW-1:0] items_seen_d;
	logic [63:0]   expected_address_d;

	always_comb begin
		item_bad = prep.static_bad
			|| (prep.aligned > cfg.max_group_bytes)
			|| (items_seen_q >= IW'(gppc_pkg::MAX_BATCH_ITEMS));
		active = !item_bad && !plan_failed_q;
		room = cfg.max_group_bytes - group_bytes_q;
		close_grp = (items_in_group_q != '0)
			&& ((items_in_group_q >= cfg.max_group_objects) || (prep.aligned > room));
		open_grp = (items_in_group_q == '0) || close_grp;
		same_dest = (prep.transport == group_transport_q)
			&& (prep.host_tag == group_host_q)
			&& (prep.port_number == group_port_q)
			&& (prep.peer_tag == group_peer_q)
			&& (prep.region_key == group_region_q)
			&& ((prep.transport != gppc_pkg::TR_FIRST) || (prep.chip == group_chip_q));
		base = open_grp ? prep.target_address : expected_address_q;
		next_addr = {1'b0, base} + {1'b0, prep.aligned};
		if (open_grp) begin
			new_fail = ((prep.transport != gppc_pkg::TR_FIRST)
				&& (prep.transport != gppc_pkg::TR_SECOND)) || prep.addr_below_meta;
		end else begin
			new_fail = !same_dest || (prep.target_address != expected_address_q);
		end
		new_fail = new_fail || next_addr[64];

		plan_failed_d = plan_failed_q || item_bad || (active && new_fail);
		items_in_group_d = items_in_group_q;
		group_bytes_d = group_bytes_q;
		groups_closed_d = groups_closed_q;
		expected_address_d = expected_address_q;
		if (active) begin
			items_in_group_d = (open_grp ? '0 : items_in_group_q) + CW'(1);
			group_bytes_d = (open_grp ? 64'd0 : group_bytes_q) + prep.aligned;
			groups_closed_d = groups_closed_q + CW'(close_grp);
			expected_address_d = next_addr[64] ? base : next_addr[63:0];
		end
		items_seen_d = (items_seen_q <= IW'(gppc_pkg::MAX_BATCH_ITEMS))
			? items_seen_q + IW'(1) : items_seen_q;

		res.starts_group = active && open_grp;
		res.group_index = active ? groups_closed_d[gppc_pkg::GIDX_W-1:0] : '0;
		res.aligned_size = prep.aligned;
		res.batch_done = prep.batch_last;
		res.plan_ok = prep.batch_last && !plan_failed_d;
		res.group_total = res.plan_ok
			? groups_closed_d + CW'(items_in_group_d != '0) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_failed_q <= 1'b0;
			items_in_group_q <= '0;
			group_bytes_q <= '0;
			groups_closed_q <= '0;
			items_seen_q <= '0;
			expected_address_q <= '0;
			group_transport_q <= '0;
			group_region_q <= '0;
			group_host_q <= '0;
			group_port_q <= '0;
			group_peer_q <= '0;
			group_chip_q <= '0;
		end else if (step) begin
			if (prep.batch_last) begin
				plan_failed_q <= 1'b0;
				items_in_group_q <= '0;
				group_bytes_q <= '0;
				groups_closed_q <= '0;
				items_seen_q <= '0;
				expected_address_q <= '0;
				group_transport_q <= '0;
				group_region_q <= '0;
				group_host_q <= '0;
				group_port_q <= '0;
				group_peer_q <= '0;
				group_chip_q <= '0;
			end else begin
				plan_failed_q <= plan_failed_d;
				items_in_group_q <= items_in_group_d;
				group_bytes_q <= group_bytes_d;
				groups_closed_q <= groups_closed_d;
				items_seen_q <= items_seen_d;
				expected_address_q <= expected_address_d;
				if (active && open_grp) begin
					group_transport_q <= prep.transport;
					group_region_q <= prep.region_key;
					group_host_q <= prep.host_tag;
					group_port_q <= prep.port_number;
					group_peer_q <= prep.peer_tag;
					group_chip_q <= prep.chip;
				end
			end
		end
	end

`ifndef SYNTH
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && prep.batch_last |=> (items_seen_q == '0) && (groups_closed_q == '0)
			&& !plan_failed_q)
		else $error("batch state not cleared after last beat");
	a_failed_ungrouped: assert property (@(posedge clk) disable iff (!arst_n)
		step && plan_failed_q |-> !res.starts_group && (res.group_index == '0))
		else $error("item grouped after plan failure");
	a_ok_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.plan_ok |-> res.batch_done && !plan_failed_q)
		else $error("plan_ok outside a clean last beat");
	a_group_filled: assert property (@(posedge clk) disable iff (!arst_n)
		step && active && !prep.batch_last |=> items_in_group_q != '0)
		else $error("grouped item left group empty");
`endif

endmodule
`default_nettype wire
